// ===== rtl/rdq_pkg.sv =====
`default_nettype none

package rdq_pkg;

  // request kinds as they arrive on the input channel
  typedef enum logic [2:0] {
    KIND_LIST       = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_PUSH_BACK  = 3'd2,
    KIND_REVERSE    = 3'd3,
    KIND_POP_FRONT  = 3'd4,
    KIND_POP_BACK   = 3'd5
  } kind_t;

  // classified operations handed from front to back
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LIST,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_REVERSE,
    OP_POP_FRONT,
    OP_POP_BACK
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // back end sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } back_state_t;

  // one queued command
  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
  } cmd_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

endpackage

`default_nettype wire

// ===== rtl/rdq_front.sv =====
`default_nettype none

module rdq_front
  import rdq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         kind,
  input  wire logic signed [31:0] value,
  output logic                    cmd_valid,
  output cmd_t                    cmd,
  input  wire logic               cmd_take
);

  cmd_t                q_mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   q_count;
  logic                accept;
  logic                take;
  cmd_t                new_cmd;

  // classify the incoming request
  always_comb begin
    new_cmd.value = value;
    case (kind)
      KIND_LIST:       new_cmd.op = OP_LIST;
      KIND_PUSH_FRONT: new_cmd.op = OP_PUSH_FRONT;
      KIND_PUSH_BACK:  new_cmd.op = OP_PUSH_BACK;
      KIND_REVERSE:    new_cmd.op = OP_REVERSE;
      KIND_POP_FRONT:  new_cmd.op = OP_POP_FRONT;
      KIND_POP_BACK:   new_cmd.op = OP_POP_BACK;
      default:         new_cmd.op = OP_NOP;
    endcase
  end

  // queue handshake
  assign in_stall  = (q_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign accept    = in_valid && !in_stall;
  assign cmd_valid = (q_count != '0);
  assign take      = cmd_take && cmd_valid;
  assign cmd       = q_mem[rd_ptr];

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + 1'b1;
      if (take) rd_ptr <= rd_ptr + 1'b1;
      case ({accept, take})
        2'b10:   q_count <= q_count + 1'b1;
        2'b01:   q_count <= q_count - 1'b1;
        default: q_count <= q_count;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) q_mem[wr_ptr] <= new_cmd;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("command queue overfilled");

  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid)
    else $error("command taken from empty queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (q_count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

// ===== rtl/rdq_back.sv =====
`default_nettype none

module rdq_back
  import rdq_pkg::*;
#(
  parameter int DEPTH = 16
)
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  input  wire cmd_t               cmd,
  output logic                    cmd_take,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      entry,
  output logic [1:0]              status,
  output logic                    last
);

  localparam int SW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [SW:0] DEPTH_X = (SW+1)'(DEPTH);

  logic signed [31:0] ring [DEPTH];
  logic signed [31:0] rd_data;

  back_state_t state;
  back_state_t state_next;
  logic [SW-1:0] front_slot;
  logic [SW-1:0] front_slot_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          reversed;
  logic          reversed_next;
  logic [SW-1:0] idx;
  logic [SW-1:0] idx_next;
  status_t       status_q;
  status_t       status_next;
  logic          last_next;
  logic          out_valid_next;
  logic          entry_sel;
  logic          entry_sel_next;

  logic          advance;
  logic          is_full;
  logic          is_empty;
  logic          list_last;
  logic          mem_we;
  logic [SW-1:0] wr_addr;
  logic          rd_en;
  logic [SW:0]   count_x;
  logic [SW:0]   idx_x;
  logic [SW:0]   back_sum;
  logic [SW-1:0] back_slot;
  logic [SW:0]   list_off;
  logic [SW:0]   list_sum;
  logic [SW-1:0] list_slot;
  logic [SW-1:0] dec_slot;
  logic [SW-1:0] inc_slot;

  assign advance   = !out_valid || !out_stall;
  assign is_full   = (count == CW'(DEPTH));
  assign is_empty  = (count == '0);
  assign count_x   = (SW+1)'(count);
  assign idx_x     = (SW+1)'(idx);
  assign list_last = ((idx_x + (SW+1)'(1)) == count_x);
  assign cmd_take  = (state == ST_IDLE) && cmd_valid && advance;

  // ring slot arithmetic, every sum stays below twice the depth
  always_comb begin
    back_sum  = (SW+1)'(front_slot) + count_x;
    back_slot = (back_sum >= DEPTH_X) ? SW'(back_sum - DEPTH_X) : SW'(back_sum);
    list_off  = reversed ? (count_x - (SW+1)'(1) - idx_x) : idx_x;
    list_sum  = (SW+1)'(front_slot) + list_off;
    list_slot = (list_sum >= DEPTH_X) ? SW'(list_sum - DEPTH_X) : SW'(list_sum);
    dec_slot  = (front_slot == '0) ? SW'(DEPTH - 1) : front_slot - 1'b1;
    inc_slot  = (front_slot == SW'(DEPTH - 1)) ? '0 : front_slot + 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_take && (cmd.op == OP_LIST) && !is_empty) state_next = ST_LIST;
      end
      ST_LIST: begin
        if (advance && list_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and result control
  always_comb begin
    front_slot_next = front_slot;
    count_next      = count;
    reversed_next   = reversed;
    idx_next        = idx;
    mem_we          = 1'b0;
    wr_addr         = back_slot;
    rd_en           = 1'b0;
    out_valid_next  = out_valid;
    status_next     = status_q;
    last_next       = last;
    entry_sel_next  = entry_sel;
    if (advance) begin
      out_valid_next = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        if (cmd_take) begin
          out_valid_next = 1'b1;
          status_next    = STATUS_DONE;
          last_next      = 1'b1;
          entry_sel_next = 1'b0;
          case (cmd.op)
            OP_LIST: begin
              idx_next = '0;
              if (is_empty) begin
                status_next = STATUS_EMPTY;
              end else begin
                out_valid_next = 1'b0;
              end
            end
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (is_full) begin
                status_next = STATUS_FULL;
              end else begin
                mem_we     = 1'b1;
                count_next = count + 1'b1;
                if ((cmd.op == OP_PUSH_FRONT) ^ reversed) begin
                  wr_addr         = dec_slot;
                  front_slot_next = dec_slot;
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (is_empty) begin
                status_next = STATUS_EMPTY;
              end else begin
                count_next = count - 1'b1;
                if ((cmd.op == OP_POP_FRONT) ^ reversed) front_slot_next = inc_slot;
              end
            end
            OP_REVERSE: reversed_next = !reversed;
            default: ;
          endcase
        end
      end
      ST_LIST: begin
        if (advance) begin
          rd_en          = 1'b1;
          out_valid_next = 1'b1;
          status_next    = STATUS_DONE;
          last_next      = list_last;
          entry_sel_next = 1'b1;
          idx_next       = idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      front_slot <= '0;
      count      <= '0;
      reversed   <= 1'b0;
      idx        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      front_slot <= front_slot_next;
      count      <= count_next;
      reversed   <= reversed_next;
      idx        <= idx_next;
      out_valid  <= out_valid_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    status_q  <= status_next;
    last      <= last_next;
    entry_sel <= entry_sel_next;
  end

  // ring memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) ring[wr_addr] <= cmd.value;
    if (rd_en) rd_data <= ring[list_slot];
  end

  assign entry  = entry_sel ? rd_data : '0;
  assign status = status_q;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    front_slot <= SW'(DEPTH - 1))
    else $error("front slot out of range");

  a_list_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LIST) |-> !is_empty)
    else $error("listing an empty store");

  a_list_frozen: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LIST) |=> $stable(count) && $stable(front_slot) && $stable(reversed))
    else $error("store changed during a listing");

endmodule

`default_nettype wire

// ===== rtl/reversible_deque_core.sv =====
`default_nettype none

// Bounded double-ended queue of signed 32-bit values kept in a ring memory of
// DEPTH slots. Requests enter a four-deep command queue and are carried out in
// order by the back end, which owns the ring, the front pointer, the fill count
// and the reverse flag. Push, pop, reverse and unused kinds each give one result
// with last set. A list first enters a listing state and then gives one result
// per stored entry, one per cycle while out_stall is low, front to back, the
// last marked; the ring's single read port sets that pace, and the back end
// takes no new request until the list ends. A list on an empty store gives one
// result with status empty. Reverse only flips a flag; no data moves. A push
// onto a full store is refused with status full; a pop on an empty store
// reports empty. Both channels hold under stall without loss.

module reversible_deque_core
  import rdq_pkg::*;
#(
  parameter int DEPTH = 16
)
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         kind,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      entry,
  output logic [1:0]              status,
  output logic                    last
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  // request intake and classification
  rdq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .value     (value),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // execution over the ring store
  rdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .entry     (entry),
    .status    (status),
    .last      (last)
  );

endmodule

`default_nettype wire
